### design/sddl_pkg.sv
// Shared types and constants for the signed decimal digit layout block.
`timescale 1ns / 1ps
package sddl_pkg;

  localparam int MAX_EMIT       = 16;
  localparam int SLOT_COUNT_DEF = 16;
  localparam int BCD_DIGITS     = 10;
  localparam int BIN_W          = 32;
  localparam int DD_STEPS       = 8;
  localparam int DD_STAGES      = BIN_W / DD_STEPS;

  localparam logic [3:0] GLYPH_MINUS     = 4'd10;
  localparam logic [3:0] GLYPH_PLUS      = 4'd11;
  localparam logic [3:0] GLYPH_ZERO_SIGN = 4'd12;

  typedef enum logic [2:0] {
    CFG_DIGIT_WIDTH  = 3'd0,
    CFG_LEAD_ZEROS   = 3'd1,
    CFG_SHOW_SIGN    = 3'd2,
    CFG_PACK_SIGN    = 3'd3,
    CFG_PATTERN_BASE = 3'd4
  } cfg_idx_t;

  typedef struct packed {
    logic [4:0]  digit_width;
    logic        show_leading_zeros;
    logic        show_sign;
    logic        pack_sign;
    logic [15:0] pattern_base;
  } cfg_t;

  // item inside the binary to BCD conversion
  typedef struct packed {
    logic                        neg;
    logic                        zero;
    logic [BCD_DIGITS-1:0][3:0]  digits;
    logic [BIN_W-1:0]            bin;
  } conv_t;

  // item after placement, ready for slot emission
  typedef struct packed {
    logic [3:0]                  sign_glyph;
    logic                        want_sign;
    logic [4:0]                  fill_n;
    logic [4:0]                  sgn_slot;
    logic [5:0]                  end_pos;
    logic [3:0]                  ndig;
    logic [BCD_DIGITS-1:0][3:0]  digits;
  } lay_t;

endpackage

### design/sddl_dabble.sv
// One pipeline stage of the shift-and-add-3 binary to BCD conversion.
`timescale 1ns / 1ps
module sddl_dabble (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  input  sddl_pkg::conv_t in_item,
  output logic           out_valid,
  input  logic           out_stall,
  output sddl_pkg::conv_t out_item
);

  logic            valid;
  sddl_pkg::conv_t item;
  sddl_pkg::conv_t item_next;

  assign in_stall  = valid && out_stall;
  assign out_valid = valid;
  assign out_item  = item;

  always_comb begin
    item_next = in_item;
    for (int s = 0; s < sddl_pkg::DD_STEPS; s++) begin
      for (int d = 0; d < sddl_pkg::BCD_DIGITS; d++) begin
        if (item_next.digits[d] >= 4'd5) begin
          item_next.digits[d] = item_next.digits[d] + 4'd3;
        end
      end
      {item_next.digits, item_next.bin} = {item_next.digits, item_next.bin} << 1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (!in_stall) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      item <= item_next;
    end
  end

endmodule

### design/sddl_place.sv
// Placement stage: digit count, sign position and digit span.
`timescale 1ns / 1ps
module sddl_place (
  input  logic            clk,
  input  logic            rst,
  input  sddl_pkg::cfg_t  cfg,
  input  logic            in_valid,
  output logic            in_stall,
  input  sddl_pkg::conv_t in_item,
  output logic            out_valid,
  input  logic            out_stall,
  output sddl_pkg::lay_t  out_item
);

  logic           valid;
  sddl_pkg::lay_t item;
  sddl_pkg::lay_t item_next;
  logic [3:0]     ndig;
  logic [4:0]     num0;
  logic [4:0]     num_pos;
  logic           packed_sign;
  logic           want;

  assign in_stall  = valid && out_stall;
  assign out_valid = valid;
  assign out_item  = item;

  always_comb begin
    ndig = 4'd1;
    for (int d = 0; d < sddl_pkg::BCD_DIGITS; d++) begin
      if (in_item.digits[d] != 4'd0) begin
        ndig = 4'(d + 1);
      end
    end

    want        = cfg.show_sign || in_item.neg;
    packed_sign = cfg.pack_sign && !cfg.show_leading_zeros;
    num0        = (cfg.digit_width > 5'(ndig)) ? (cfg.digit_width - 5'(ndig)) : 5'd0;
    num_pos     = (want && num0 == 5'd0) ? 5'd1 : num0;

    item_next.want_sign = want;
    item_next.sgn_slot  = (packed_sign && num0 != 5'd0) ? (num0 - 5'd1) : 5'd0;
    item_next.sign_glyph = in_item.neg  ? sddl_pkg::GLYPH_MINUS :
                           in_item.zero ? sddl_pkg::GLYPH_ZERO_SIGN : sddl_pkg::GLYPH_PLUS;
    item_next.fill_n  = cfg.show_leading_zeros ? cfg.digit_width : 5'd0;
    item_next.end_pos = 6'(num_pos) + 6'(ndig) - 6'd1;
    item_next.ndig    = ndig;
    item_next.digits  = in_item.digits;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (!in_stall) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      item <= item_next;
    end
  end

endmodule

### design/sddl_emit.sv
// Slot serializer: one result per slot from a held placed item.
`timescale 1ns / 1ps
module sddl_emit #(
  parameter int SLOT_COUNT = sddl_pkg::SLOT_COUNT_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  sddl_pkg::cfg_t cfg,
  input  logic           in_valid,
  output logic           in_stall,
  input  sddl_pkg::lay_t in_item,
  output logic           out_valid,
  input  logic           out_stall,
  output logic [3:0]     slot_index,
  output logic           visible,
  output logic [16:0]    pattern,
  output logic           overflow,
  output logic           last
);

  localparam int N_SLOT = (SLOT_COUNT < sddl_pkg::MAX_EMIT) ? SLOT_COUNT : sddl_pkg::MAX_EMIT;
  localparam int SLOT_W = $clog2(N_SLOT);

  logic              valid;
  logic [SLOT_W-1:0] cnt;
  sddl_pkg::lay_t    item;
  logic              take;
  logic              fin;
  logic [5:0]        pos;
  logic [5:0]        from_end;
  logic              is_digit;
  logic              is_sign;
  logic [3:0]        glyph;

  assign take     = valid && !out_stall;
  assign last     = (cnt == SLOT_W'(N_SLOT - 1));
  assign fin      = take && last;
  assign in_stall = valid && !fin;

  assign out_valid  = valid;
  assign slot_index = 4'(cnt);

  always_comb begin
    pos      = 6'(cnt);
    from_end = item.end_pos - pos;
    is_digit = (pos <= item.end_pos) && (from_end < 6'(item.ndig));
    is_sign  = item.want_sign && (5'(cnt) == item.sgn_slot);
    if (is_sign) begin
      glyph = item.sign_glyph;
    end else if (is_digit) begin
      glyph = item.digits[from_end[3:0]];
    end else begin
      glyph = 4'd0;
    end
    visible  = is_sign || is_digit || (5'(cnt) < item.fill_n);
    pattern  = 17'(cfg.pattern_base) + 17'(glyph);
    overflow = (item.end_pos >= 6'(N_SLOT));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      cnt   <= '0;
    end else if (!in_stall) begin
      valid <= in_valid;
      cnt   <= '0;
    end else if (take) begin
      cnt <= cnt + SLOT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      item <= in_item;
    end
  end

endmodule

### design/signed_decimal_digit_layout_top.sv
// Top level of the signed decimal digit layout block.
`timescale 1ns / 1ps
//
//  channel  | signals                              | moves
//  ---------+--------------------------------------+-------------------------------
//  input    | in_valid, in_stall, value            | one signed value per item
//  output   | out_valid, out_stall, slot_index,    | one item per display slot,
//           | visible, pattern, overflow, last     | slot 0 first, last on final
//  config   | cfg_valid, cfg_ready, cfg_index,     | register writes, always ready
//           | cfg_data                             |
//
//  Each value yields min(SLOT_COUNT, 16) output items, one per cycle unless
//  out_stall holds them; the serializer takes the next value on the last slot.
//  Pipeline: input clamp stage, four BCD conversion stages (8 bits each),
//  placement stage and serializer, each a registered stage, in that order.
//  Synchronous reset clears valids, slot counter and config registers.
//  Stalls ripple back stage by stage; a full stage holds its item.
module signed_decimal_digit_layout_top #(
  parameter int SLOT_COUNT = sddl_pkg::SLOT_COUNT_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] value,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [3:0]         slot_index,
  output logic               visible,
  output logic [16:0]        pattern,
  output logic               overflow,
  output logic               last,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data
);

  sddl_pkg::cfg_t  cfg;

  // input stage: clamp and magnitude
  logic            s0_valid;
  logic            s0_stall;
  sddl_pkg::conv_t s0_item;
  sddl_pkg::conv_t s0_next;
  logic [31:0]     raw;

  // conversion chain
  logic            dv [sddl_pkg::DD_STAGES+1];
  logic            ds [sddl_pkg::DD_STAGES+1];
  sddl_pkg::conv_t di [sddl_pkg::DD_STAGES+1];

  logic            pl_valid;
  logic            pl_stall;
  sddl_pkg::lay_t  pl_item;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (sddl_pkg::cfg_idx_t'(cfg_index))
        sddl_pkg::CFG_DIGIT_WIDTH:  cfg.digit_width        <= cfg_data[4:0];
        sddl_pkg::CFG_LEAD_ZEROS:   cfg.show_leading_zeros <= cfg_data[0];
        sddl_pkg::CFG_SHOW_SIGN:    cfg.show_sign          <= cfg_data[0];
        sddl_pkg::CFG_PACK_SIGN:    cfg.pack_sign          <= cfg_data[0];
        sddl_pkg::CFG_PATTERN_BASE: cfg.pattern_base       <= cfg_data;
        default: ;
      endcase
    end
  end

  // most negative value shows as -2147483647
  always_comb begin
    raw = (value == 32'sh8000_0000) ? 32'h8000_0001 : 32'(value);
    s0_next.neg    = raw[31];
    s0_next.bin    = raw[31] ? (32'd0 - raw) : raw;
    s0_next.zero   = (raw == 32'd0);
    s0_next.digits = '0;
  end

  assign in_stall = s0_valid && s0_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else if (!in_stall) begin
      s0_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s0_item <= s0_next;
    end
  end

  assign dv[0]    = s0_valid;
  assign di[0]    = s0_item;
  assign s0_stall = ds[0];

  for (genvar g = 0; g < sddl_pkg::DD_STAGES; g++) begin : g_dd
    sddl_dabble u_dabble (
      .clk      (clk),
      .rst      (rst),
      .in_valid (dv[g]),
      .in_stall (ds[g]),
      .in_item  (di[g]),
      .out_valid(dv[g+1]),
      .out_stall(ds[g+1]),
      .out_item (di[g+1])
    );
  end

  sddl_place u_place (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .in_valid (dv[sddl_pkg::DD_STAGES]),
    .in_stall (ds[sddl_pkg::DD_STAGES]),
    .in_item  (di[sddl_pkg::DD_STAGES]),
    .out_valid(pl_valid),
    .out_stall(pl_stall),
    .out_item (pl_item)
  );

  sddl_emit #(
    .SLOT_COUNT(SLOT_COUNT)
  ) u_emit (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (pl_valid),
    .in_stall  (pl_stall),
    .in_item   (pl_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .slot_index(slot_index),
    .visible   (visible),
    .pattern   (pattern),
    .overflow  (overflow),
    .last      (last)
  );

endmodule

### sim/signed_decimal_digit_layout_top_test.sv
// Self-checking testbench for the signed decimal digit layout block.
`timescale 1ns / 1ps
module signed_decimal_digit_layout_top_test;

  // Slots the block emits per value; the default slot count is used.
  localparam int SLOTS = (sddl_pkg::SLOT_COUNT_DEF < sddl_pkg::MAX_EMIT) ?
                         sddl_pkg::SLOT_COUNT_DEF : sddl_pkg::MAX_EMIT;
  // Watchdog, well above the slowest legal run (about 230 values x 16 slots
  // with heavy output stalls, sender gaps and one long hold-off).
  localparam int LIMIT_CYCLES = 400000;
  localparam int HOLD_CYCLES  = 300;
  localparam int HOLD_AFTER   = 40;
  localparam int RAND_PHASES  = 11;
  localparam int RAND_PER_PHASE = 16;
  // Index past the register list; a write there must change nothing.
  localparam logic [2:0] CFG_SPARE = sddl_pkg::CFG_PATTERN_BASE + 3'd1;

  // One expected or observed output item.
  typedef struct {
    logic [3:0]  slot;
    logic        vis;
    logic [16:0] pat;
    logic        ovf;
    logic        fin;
  } slot_item_t;

  // Predicts the slot items of each accepted value and checks the output.
  class layout_scoreboard;
    sddl_pkg::cfg_t regs;
    slot_item_t     expected_slots[$];
    int             errors;
    int             reported;

    function new();
      regs     = '0;
      errors   = 0;
      reported = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [15:0] d);
      case (idx)
        sddl_pkg::CFG_DIGIT_WIDTH:  regs.digit_width        = d[4:0];
        sddl_pkg::CFG_LEAD_ZEROS:   regs.show_leading_zeros = d[0];
        sddl_pkg::CFG_SHOW_SIGN:    regs.show_sign          = d[0];
        sddl_pkg::CFG_PACK_SIGN:    regs.pack_sign          = d[0];
        sddl_pkg::CFG_PATTERN_BASE: regs.pattern_base       = d;
        default: ;
      endcase
    endfunction

    // Lays the value out across the slots and queues one item per slot.
    function void layout_value(logic [31:0] v);
      logic [31:0] raw;
      logic [31:0] mag;
      logic [31:0] t;
      logic        neg;
      logic        want_sign;
      logic        packed_sign;
      logic        ovf;
      logic [3:0]  sign_glyph;
      logic [3:0]  rev[10];
      logic [3:0]  digs[10];
      logic [3:0]  glyph[sddl_pkg::MAX_EMIT];
      logic        vis[sddl_pkg::MAX_EMIT];
      int          ndig;
      int          width;
      int          num_pos;
      int          sgn_at;
      int          p;
      slot_item_t  it;

      raw  = v;
      neg  = raw[31];
      // most negative value is shown one step smaller in magnitude
      if (raw == 32'h8000_0000) raw = 32'h8000_0001;
      mag  = neg ? (32'd0 - raw) : raw;
      ndig = 0;
      if (mag == 32'd0) begin
        digs[0] = 4'd0;
        ndig    = 1;
      end else begin
        t = mag;
        while (t != 32'd0 && ndig < 10) begin
          rev[ndig] = 4'(t % 32'd10);
          t         = t / 32'd10;
          ndig++;
        end
        for (int i = 0; i < ndig; i++) digs[i] = rev[ndig - 1 - i];
      end

      if (neg) sign_glyph = sddl_pkg::GLYPH_MINUS;
      else if (mag == 32'd0) sign_glyph = sddl_pkg::GLYPH_ZERO_SIGN;
      else sign_glyph = sddl_pkg::GLYPH_PLUS;

      want_sign   = regs.show_sign || neg;
      // zero fill overrides packing: sign goes to slot 0
      packed_sign = regs.pack_sign && !regs.show_leading_zeros;
      width       = int'(regs.digit_width);
      ovf         = 1'b0;
      sgn_at      = 0;

      for (int i = 0; i < sddl_pkg::MAX_EMIT; i++) begin
        glyph[i] = 4'd0;
        vis[i]   = 1'b0;
      end
      // zero fill past the last slot is dropped without overflow
      if (regs.show_leading_zeros) begin
        for (int i = 0; i < width && i < SLOTS; i++) vis[i] = 1'b1;
      end

      num_pos = width - ndig;
      if (num_pos < 0) num_pos = 0;
      if (want_sign) begin
        if (packed_sign) begin
          sgn_at = num_pos - 1;
          if (sgn_at < 0) sgn_at = 0;
        end
        if (num_pos < sgn_at + 1) num_pos = sgn_at + 1;
      end

      for (int i = 0; i < ndig; i++) begin
        p = num_pos + i;
        if (p < SLOTS) begin
          glyph[p] = digs[i];
          vis[p]   = 1'b1;
        end else begin
          ovf = 1'b1;
        end
      end
      if (want_sign) begin
        if (sgn_at < SLOTS) begin
          glyph[sgn_at] = sign_glyph;
          vis[sgn_at]   = 1'b1;
        end else begin
          ovf = 1'b1;
        end
      end

      for (int i = 0; i < SLOTS; i++) begin
        it.slot = 4'(i);
        it.vis  = vis[i];
        it.pat  = 17'(glyph[i]) + 17'(regs.pattern_base);
        it.ovf  = ovf;
        it.fin  = (i == SLOTS - 1);
        expected_slots.push_back(it);
      end
    endfunction

    function void check_slot(slot_item_t got);
      slot_item_t exp_it;
      if (expected_slots.size() == 0) begin
        errors++;
        if (reported < 10) begin
          reported++;
          $display("[%0t] unexpected slot item: slot %0d vis %0b pat %0d ovf %0b last %0b",
                   $realtime, got.slot, got.vis, got.pat, got.ovf, got.fin);
        end
        return;
      end
      exp_it = expected_slots.pop_front();
      if (got.slot !== exp_it.slot || got.vis !== exp_it.vis || got.pat !== exp_it.pat ||
          got.ovf !== exp_it.ovf || got.fin !== exp_it.fin) begin
        errors++;
        if (reported < 10) begin
          reported++;
          $display("[%0t] slot mismatch: exp slot %0d vis %0b pat %0d ovf %0b last %0b",
                   $realtime, exp_it.slot, exp_it.vis, exp_it.pat, exp_it.ovf, exp_it.fin);
          $display("                    got slot %0d vis %0b pat %0d ovf %0b last %0b",
                   got.slot, got.vis, got.pat, got.ovf, got.fin);
        end
      end
    endfunction

    // Anything still queued at the end never came out.
    function void close_out();
      errors += expected_slots.size();
      if (expected_slots.size() != 0)
        $display("%0d slot items never arrived", expected_slots.size());
    endfunction
  endclass

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_stall;
  logic signed [31:0] value;
  logic               out_valid;
  logic               out_stall;
  logic [3:0]         slot_index;
  logic               visible;
  logic [16:0]        pattern;
  logic               overflow;
  logic               last;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [2:0]         cfg_index;
  logic [15:0]        cfg_data;

  layout_scoreboard sb;
  int               values_accepted;
  int               cycles;

  signed_decimal_digit_layout_top i_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .value      (value),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .slot_index (slot_index),
    .visible    (visible),
    .pattern    (pattern),
    .overflow   (overflow),
    .last       (last),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Watchdog: ends the run if the stimulus or the drain never completes.
  initial begin
    cycles = 0;
    while (cycles < LIMIT_CYCLES) begin
      @(posedge clk);
      cycles++;
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Driving tasks. All run from a rising edge and leave at one.
  // --------------------------------------------------------------------------

  // Offers one value and holds it until the block takes it.
  task automatic send_value(input logic [31:0] v);
    in_valid <= 1'b1;
    value    <= v;
    do @(posedge clk); while (in_stall);
    sb.layout_value(v);
    values_accepted++;
  endtask

  // Sender gap; a zero-length gap keeps valid high into the next item.
  task automatic sender_gap(input int n);
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // Register write; valid is left high so back-to-back writes don't glitch it.
  task automatic write_reg(input logic [2:0] idx, input logic [15:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, d);
  endtask

  // Writes every register; unused data bits carry noise the block must ignore.
  task automatic load_config(input sddl_pkg::cfg_t c, input bit poke_spare);
    logic [15:0] noise;
    noise = 16'($urandom);
    write_reg(sddl_pkg::CFG_DIGIT_WIDTH, {noise[15:5], c.digit_width});
    noise = 16'($urandom);
    write_reg(sddl_pkg::CFG_LEAD_ZEROS, {noise[15:1], c.show_leading_zeros});
    noise = 16'($urandom);
    write_reg(sddl_pkg::CFG_SHOW_SIGN, {noise[15:1], c.show_sign});
    noise = 16'($urandom);
    write_reg(sddl_pkg::CFG_PACK_SIGN, {noise[15:1], c.pack_sign});
    write_reg(sddl_pkg::CFG_PATTERN_BASE, c.pattern_base);
    if (poke_spare) write_reg(CFG_SPARE, 16'($urandom));
    cfg_valid <= 1'b0;
  endtask

  // Sender pause until every queued slot item has come out.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (sb.expected_slots.size() != 0) @(posedge clk);
  endtask

  // Random value: full range, small numbers, decade edges and extremes.
  function automatic logic [31:0] pick_value();
    logic [31:0] pw;
    logic [31:0] v;
    int          k;
    case ($urandom_range(0, 4))
      0: v = $urandom;
      1: v = 32'($urandom_range(0, 20)) - 32'd10;
      2: begin
        v = 32'($urandom_range(0, 99999));
        if ($urandom_range(0, 1)) v = 32'd0 - v;
      end
      3: begin
        // powers of ten and one below them, to hit every digit count
        k  = $urandom_range(0, 9);
        pw = 32'd1;
        for (int i = 0; i < k; i++) pw = pw * 32'd10;
        v = $urandom_range(0, 1) ? pw : pw - 32'd1;
        if ($urandom_range(0, 1)) v = 32'd0 - v;
      end
      default: begin
        case ($urandom_range(0, 3))
          0: v = 32'h8000_0000;
          1: v = 32'h7FFF_FFFF;
          2: v = 32'h8000_0001;
          default: v = 32'd0;
        endcase
      end
    endcase
    return v;
  endfunction

  function automatic sddl_pkg::cfg_t pick_config();
    sddl_pkg::cfg_t c;
    // widths past the slot row are legal and force overflow
    c.digit_width        = ($urandom_range(0, 3) == 0) ? 5'($urandom_range(17, 31))
                                                        : 5'($urandom_range(0, 16));
    c.show_leading_zeros = 1'($urandom_range(0, 1));
    c.show_sign          = 1'($urandom_range(0, 1));
    c.pack_sign          = 1'($urandom_range(0, 1));
    c.pattern_base       = $urandom_range(0, 2) == 0 ? 16'd0 : 16'($urandom);
    return c;
  endfunction

  // --------------------------------------------------------------------------
  // Output side: checker and stall pattern.
  // --------------------------------------------------------------------------

  always @(posedge clk) begin
    slot_item_t got;
    if (!rst && out_valid && !out_stall) begin
      got.slot = slot_index;
      got.vis  = visible;
      got.pat  = pattern;
      got.ovf  = overflow;
      got.fin  = last;
      sb.check_slot(got);
    end
  end

  // Receiver works in segments: free running, random stalls, or stall runs.
  // Once, a long hold-off lets the pipeline fill and back up into the input.
  initial begin
    bit held;
    bit run_stall;
    int seg_len;
    int mode;
    int run;
    held      = 1'b0;
    run_stall = 1'b0;
    run       = 0;
    out_stall <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      if (!held && values_accepted >= HOLD_AFTER) begin
        held = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      seg_len = $urandom_range(5, 60);
      mode    = $urandom_range(0, 2);
      repeat (seg_len) begin
        case (mode)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 2) == 0);
          default: begin
            // alternating runs of stall and flow, of random length
            if (run == 0) begin
              run       = $urandom_range(1, 8);
              run_stall = !run_stall;
            end
            run--;
            out_stall <= run_stall;
          end
        endcase
        @(posedge clk);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------

  initial begin
    logic [31:0]    directed[$];
    sddl_pkg::cfg_t fixed_cfgs[$];
    sddl_pkg::cfg_t c;
    int             burst_left;

    sb              = new();
    values_accepted = 0;
    burst_left      = 0;
    rst       <= 1'b1;
    in_valid  <= 1'b0;
    value     <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= sddl_pkg::CFG_DIGIT_WIDTH;
    cfg_data  <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed values under the reset settings: zero, sign edges, clamped
    // most negative value, digit count boundaries at 10, 100 and 1000000000.
    directed = '{32'd0, 32'd1, 32'hFFFF_FFFF, 32'd9, 32'd10, -32'sd10, 32'd99,
                 32'd100, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0001,
                 32'd1000000000, -32'sd1000000000, 32'd999999999, 32'd12345,
                 -32'sd7};
    foreach (directed[i]) send_value(directed[i]);
    wait_drained();

    // Extreme settings first: widest base, widths at 0, 16 and 31, sign
    // packed, sign at slot 0, zero fill overriding packing.
    fixed_cfgs = '{
      '{digit_width: 5'd16, show_leading_zeros: 1'b1, show_sign: 1'b1, pack_sign: 1'b1,
        pattern_base: 16'hFFFF},
      '{digit_width: 5'd31, show_leading_zeros: 1'b0, show_sign: 1'b1, pack_sign: 1'b1,
        pattern_base: 16'd0},
      '{digit_width: 5'd0, show_leading_zeros: 1'b0, show_sign: 1'b1, pack_sign: 1'b1,
        pattern_base: 16'd1},
      '{digit_width: 5'd8, show_leading_zeros: 1'b0, show_sign: 1'b1, pack_sign: 1'b0,
        pattern_base: 16'd100},
      '{digit_width: 5'd12, show_leading_zeros: 1'b1, show_sign: 1'b0, pack_sign: 1'b0,
        pattern_base: 16'hFFFF},
      '{digit_width: 5'd31, show_leading_zeros: 1'b1, show_sign: 1'b1, pack_sign: 1'b0,
        pattern_base: 16'h8000}
    };

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      c = (ph < fixed_cfgs.size()) ? fixed_cfgs[ph] : pick_config();
      load_config(c, ph == 2);
      // each setting sees zero, the clamp case and the positive extreme
      send_value(32'd0);
      send_value(32'h8000_0000);
      send_value(32'h7FFF_FFFF);
      for (int n = 0; n < RAND_PER_PHASE; n++) begin
        if (burst_left == 0) begin
          sender_gap($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 40));
          burst_left = $urandom_range(1, 10);
        end
        burst_left--;
        send_value(pick_value());
      end
      wait_drained();
    end

    // Let any stray output show up before the verdict.
    repeat (40) @(posedge clk);
    sb.close_out();
    if (sb.errors == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

### signed_decimal_digit_layout_top.f
design/sddl_pkg.sv
design/sddl_dabble.sv
design/sddl_place.sv
design/sddl_emit.sv
design/signed_decimal_digit_layout_top.sv
sim/signed_decimal_digit_layout_top_test.sv
